// ----- sv/pcxrp_pkg.sv -----
// Shared constants and types for the PCX planar RLE to RGBA decoder.
package pcxrp_pkg;

  // Default limits handed to the top level parameters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Fixed field widths
  localparam int BYTE_BITS     = 8;
  localparam int RUN_BITS      = 6;
  localparam int CFG_W_BITS    = 11;
  localparam int CFG_H_BITS    = 13;
  localparam int CFG_DATA_BITS = 13;
  localparam int CFG_IDX_BITS  = 1;
  localparam int ROW_BITS      = 12;
  localparam int COL_BITS      = 10;
  localparam int IN_TDATA_BITS  = 8;
  localparam int OUT_TDATA_BITS = 56;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Byte codes
  localparam logic [1:0]           RUN_MARK    = 2'b11;
  localparam logic [BYTE_BITS-1:0] ALPHA_CLEAR = 8'd0;
  localparam logic [BYTE_BITS-1:0] ALPHA_OPAQUE = 8'd255;

  // Where the current line position falls
  typedef struct packed {
    logic past_end;  // position already at or beyond the line end
    logic is_red;
    logic is_green;
    logic is_blue;
    logic closes;    // placing a byte here closes the line
  } pos_flags_t;

endpackage

// ----- sv/pcxrp_ram.sv -----
// Generic single write, single read RAM with registered read data.
module pcxrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/pcxrp_cfg.sv -----
// Configuration registers with clamped width, height and derived plane limits.
module pcxrp_cfg import pcxrp_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int PW = $clog2(3 * MAX_WIDTH + 1),
  localparam int SW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output logic [PW-1:0]            eff_w,
  output logic [PW-1:0]            eff_w2,
  output logic [PW-1:0]            eff_lim,
  output logic [SW-1:0]            eff_h
);

  logic [31:0] wv;
  logic [31:0] hv;

  // Clamp the written values into their legal ranges
  always_comb begin
    wv = 32'(cfg_data[CFG_W_BITS-1:0]);
    if (wv == 32'd0) begin
      wv = 32'd1;
    end else if (wv > 32'(MAX_WIDTH)) begin
      wv = 32'(MAX_WIDTH);
    end
    hv = 32'(cfg_data[CFG_H_BITS-1:0]);
    if (hv == 32'd0) begin
      hv = 32'd1;
    end else if (hv > 32'(MAX_HEIGHT)) begin
      hv = 32'(MAX_HEIGHT);
    end
  end

  // Width, twice width and line length are all set on a width write
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w   <= PW'(1);
      eff_w2  <= PW'(2);
      eff_lim <= PW'(3);
      eff_h   <= SW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          eff_w   <= wv[PW-1:0];
          eff_w2  <= PW'(wv << 1);
          eff_lim <= PW'(wv + (wv << 1));
        end
        REG_IMAGE_HEIGHT: begin
          eff_h <= hv[SW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/pcxrp_pos.sv -----
// Line position unit: shared compare and subtract that maps the fill count to a plane slot.
module pcxrp_pos import pcxrp_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int PW = $clog2(3 * MAX_WIDTH + 1),
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic [PW-1:0] fill,
  input  logic [PW-1:0] w,
  input  logic [PW-1:0] w2,
  input  logic [PW-1:0] lim,
  output pos_flags_t    flags,
  output logic [AW-1:0] idx
);

  logic [PW-1:0] base;
  logic [PW-1:0] diff;
  logic [PW:0]   fill_inc;

  // Plane select and offset within the plane
  always_comb begin
    flags.past_end = (fill >= lim);
    flags.is_red   = (fill < w);
    flags.is_green = !flags.is_red && (fill < w2);
    flags.is_blue  = !flags.is_red && !flags.is_green && !flags.past_end;
    if (flags.is_red) begin
      base = '0;
    end else if (flags.is_green) begin
      base = w;
    end else begin
      base = w2;
    end
    diff = fill - base;
    idx  = diff[AW-1:0];
    fill_inc = {1'b0, fill} + (PW+1)'(1);
    flags.closes = (fill_inc >= {1'b0, lim});
  end

endmodule

// ----- sv/pcx_rle_planar_to_rgba_top.sv -----
// Top level of the PCX planar RLE decoder: byte sequencer, line store and pixel output.
//
// Compressed image bytes enter on s_axis, one byte per request. A byte with both top
// bits set is a run marker; the byte after it is repeated by the marker's low six bits.
// Decoded bytes fill red, green and blue planes of each scanline; red and green go to
// two line RAMs, and each blue byte produces one RGBA pixel on m_axis.
// Flow: an input request is taken only while the sequencer is idle, so the input is
// held until a run is done. A marker or an ignored byte is handled in the idle state.
// Each decoded red or green byte takes a position step; each blue byte takes a step
// and then the registered RAM read in the load state, which waits while the output
// is stalled, and from there its pixel goes into the m_axis output register. Width and
// height must be written on the cfg port only while the block is idle; the user is
// bound, the block does not enforce it. Reset (rst, synchronous) returns to the start
// of an image with width and height 1; the line RAMs are not cleared. If the receiver
// stalls, the pixel is held in the output register and the sequencer waits with the
// next pixel's RAM data held.
module pcx_rle_planar_to_rgba_top import pcxrp_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,   // [7:0] data_byte
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [11:0] pix_row, [21:12] pix_col, [29:22] red, [37:30] green,
  // [45:38] blue, [53:46] alpha, [55:54] zero
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  output logic                      m_axis_tlast,   // last_of_run
  output logic                      m_axis_tuser,   // image_done
  input  logic                      cfg_we,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int PW = $clog2(3 * MAX_WIDTH + 1);
  localparam int SW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_STEP = 3'b010,
    ST_LOAD = 3'b100
  } state_t;

  state_t               state;
  logic [PW-1:0]        line_fill;
  logic [SW-1:0]        scanline;
  logic                 await_val;
  logic [RUN_BITS-1:0]  run_len;
  logic                 finished;
  logic [RUN_BITS-1:0]  remain;
  logic [BYTE_BITS-1:0] cur_byte;
  logic [AW-1:0]        jreg;
  logic [ROW_BITS-1:0]  pend_row;
  logic                 pend_last;
  logic                 pend_done;
  logic                 pend_more;

  logic [PW-1:0]        eff_w;
  logic [PW-1:0]        eff_w2;
  logic [PW-1:0]        eff_lim;
  logic [SW-1:0]        eff_h;

  pos_flags_t           flags;
  logic [AW-1:0]        pos_idx;
  logic [AW-1:0]        rd_addr;
  logic [BYTE_BITS-1:0] red_rd;
  logic [BYTE_BITS-1:0] grn_rd;
  logic                 red_we;
  logic                 grn_we;

  logic                 in_acc;
  logic                 out_free;
  logic                 last_iter;
  logic [SW:0]          scan_inc;
  logic [31:0]          row_full;
  logic [31:0]          col_full;
  logic                 out_black;

  pcxrp_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .eff_w    (eff_w),
    .eff_w2   (eff_w2),
    .eff_lim  (eff_lim),
    .eff_h    (eff_h)
  );

  pcxrp_pos #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_pos (
    .fill (line_fill),
    .w    (eff_w),
    .w2   (eff_w2),
    .lim  (eff_lim),
    .flags(flags),
    .idx  (pos_idx)
  );

  // Line store: red plane and green plane
  pcxrp_ram #(
    .WIDTH(BYTE_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_red_ram (
    .clk  (clk),
    .we   (red_we),
    .waddr(pos_idx),
    .wdata(cur_byte),
    .raddr(rd_addr),
    .rdata(red_rd)
  );

  pcxrp_ram #(
    .WIDTH(BYTE_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_grn_ram (
    .clk  (clk),
    .we   (grn_we),
    .waddr(pos_idx),
    .wdata(cur_byte),
    .raddr(rd_addr),
    .rdata(grn_rd)
  );

  // Handshake and per-step decode
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    in_acc    = s_axis_tvalid && s_axis_tready;
    out_free  = !m_axis_tvalid || m_axis_tready;
    red_we    = (state == ST_STEP) && flags.is_red;
    grn_we    = (state == ST_STEP) && flags.is_green;
    // keep the address steady while a pixel waits so the read data holds
    rd_addr   = (state == ST_LOAD) ? jreg : pos_idx;
    last_iter = (remain == RUN_BITS'(1)) || flags.closes;
    scan_inc  = {1'b0, scanline} + (SW+1)'(1);
    row_full  = 32'(eff_h) - 32'd1 - 32'(scanline);
    col_full  = 32'(jreg);
    out_black = (red_rd == '0) && (grn_rd == '0) && (cur_byte == '0);
  end

  // Sequencer and line position
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      line_fill <= '0;
      scanline  <= '0;
      await_val <= 1'b0;
      run_len   <= '0;
      finished  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc && !finished) begin
            cur_byte <= s_axis_tdata[BYTE_BITS-1:0];
            if (scanline >= eff_h) begin
              finished <= 1'b1;
            end else if (await_val) begin
              await_val <= 1'b0;
              remain    <= run_len;
              if (run_len != '0) begin
                state <= ST_STEP;
              end
            end else if (s_axis_tdata[7:6] == RUN_MARK) begin
              run_len   <= s_axis_tdata[RUN_BITS-1:0];
              await_val <= 1'b1;
            end else begin
              remain <= RUN_BITS'(1);
              state  <= ST_STEP;
            end
          end
        end
        ST_STEP: begin
          if (flags.past_end) begin
            // line already full: close it and drop the rest of the run
            line_fill <= '0;
            scanline  <= scanline + SW'(1);
            if (scan_inc >= {1'b0, eff_h}) begin
              finished <= 1'b1;
            end
            state <= ST_IDLE;
          end else begin
            remain <= remain - RUN_BITS'(1);
            if (flags.closes) begin
              line_fill <= '0;
              scanline  <= scanline + SW'(1);
              if (scan_inc >= {1'b0, eff_h}) begin
                finished <= 1'b1;
              end
            end else begin
              line_fill <= line_fill + PW'(1);
            end
            if (flags.is_blue) begin
              jreg      <= pos_idx;
              pend_row  <= row_full[ROW_BITS-1:0];
              pend_last <= last_iter;
              pend_done <= flags.closes && (scan_inc == {1'b0, eff_h});
              pend_more <= !last_iter;
              state     <= ST_LOAD;
            end else if (last_iter) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_LOAD: begin
          if (out_free) begin
            state <= pend_more ? ST_STEP : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_LOAD && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD && out_free) begin
      m_axis_tdata <= {2'b00,
                       out_black ? ALPHA_CLEAR : ALPHA_OPAQUE,
                       cur_byte, grn_rd, red_rd,
                       col_full[COL_BITS-1:0], pend_row};
      m_axis_tlast <= pend_last;
      m_axis_tuser <= pend_done;
    end
  end

`ifndef NO_ASSERTIONS
  // A new pixel only ever comes out of the load state
  a_pix_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_LOAD))
    else $error("pixel appeared without a line store read");

  // The last pixel of the image always closes its run
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("image_done without last_of_run");

  // No line store write while a read is held for a waiting pixel
  a_no_write_in_load: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> !red_we && !grn_we)
    else $error("line store written during pixel load");

  // A blue byte within the line always goes on to fetch its pixel
  a_blue_to_load: assert property (@(posedge clk) disable iff (rst)
    state == ST_STEP && flags.is_blue |=> state == ST_LOAD)
    else $error("blue byte did not start a pixel load");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the PCX planar RLE to RGBA decoder top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcxrp_pkg::*;

  // Quiet time after the last pixel, for a full run of blue bytes to drain
  localparam int SETTLE_CYCLES = 200;
  // Worst case of roughly 250 requests at 63 pixels, each pixel stalled by the receiver
  localparam int CYCLE_LIMIT   = 800000;
  localparam int HOLD_CYCLES   = 400;

  typedef enum int {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_e;

  typedef struct {
    logic [ROW_BITS-1:0]  row;
    logic [COL_BITS-1:0]  col;
    logic [BYTE_BITS-1:0] red;
    logic [BYTE_BITS-1:0] green;
    logic [BYTE_BITS-1:0] blue;
    logic [BYTE_BITS-1:0] alpha;
    logic                 last;
    logic                 done;
  } pixel_t;

  // Decoder state mirror plus the queue of pixels still owed by the block
  class pixel_tracker;
    logic [BYTE_BITS-1:0]  plane [2*DEF_MAX_WIDTH];
    logic [CFG_W_BITS-1:0] width_reg;
    logic [CFG_H_BITS-1:0] height_reg;
    logic [RUN_BITS-1:0]   run_len;
    int                    fill;
    int                    scan;
    bit                    await_val;
    bit                    finished;
    pixel_t                pending [$];
    int                    mismatches;
    int                    seen;

    function new();
      foreach (plane[i]) plane[i] = '0;
      width_reg  = 1;
      height_reg = 1;
      run_len    = '0;
      fill       = 0;
      scan       = 0;
      await_val  = 0;
      finished   = 0;
      mismatches = 0;
      seen       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      if (idx == REG_IMAGE_WIDTH) width_reg = val[CFG_W_BITS-1:0];
      else if (idx == REG_IMAGE_HEIGHT) height_reg = val[CFG_H_BITS-1:0];
    endfunction

    function void close_line(int h);
      fill = 0;
      scan++;
      if (scan >= h) finished = 1;
    endfunction

    // Decode one accepted byte and queue the pixels it completes
    function void take_byte(logic [BYTE_BITS-1:0] b);
      int     w;
      int     h;
      int     lim;
      int     cnt;
      int     p;
      int     j;
      bit     have;
      bit     stop;
      pixel_t px;
      pixel_t prev;
      w = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
      h = (height_reg == 0) ? 1 :
          (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(height_reg);
      lim  = 3 * w;
      have = 0;
      stop = 0;
      if (finished) return;
      // height lowered below the lines already done
      if (scan >= h) begin
        finished = 1;
        return;
      end
      if (await_val) begin
        cnt       = int'(run_len);
        await_val = 0;
      end else if (b[7:6] == RUN_MARK) begin
        run_len   = b[RUN_BITS-1:0];
        await_val = 1;
        return;
      end else begin
        cnt = 1;
      end
      for (int k = 0; k < cnt && !stop; k++) begin
        p = fill;
        if (p >= lim) begin
          // width lowered mid-line: rest of the run is dropped
          close_line(h);
          stop = 1;
        end else begin
          if (p < w) begin
            plane[p] = b;
          end else if (p < 2 * w) begin
            plane[DEF_MAX_WIDTH + p - w] = b;
          end else begin
            j         = p - 2 * w;
            px.row    = ROW_BITS'(h - 1 - scan);
            px.col    = COL_BITS'(j);
            px.red    = plane[j];
            px.green  = plane[DEF_MAX_WIDTH + j];
            px.blue   = b;
            px.alpha  = (px.red == 0 && px.green == 0 && b == 0) ? ALPHA_CLEAR : ALPHA_OPAQUE;
            px.last   = 1'b0;
            px.done   = (p == lim - 1 && scan == h - 1);
            if (have) pending.push_back(prev);
            prev = px;
            have = 1;
          end
          fill = p + 1;
          if (fill >= lim) begin
            close_line(h);
            stop = 1;
          end
        end
      end
      if (have) begin
        prev.last = 1'b1;
        pending.push_back(prev);
      end
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] %s", $time, msg);
    endtask

    task compare(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("pixel %0d %s: got 0x%0h, want 0x%0h", seen, name, got, want));
    endtask

    // Check one accepted pixel against the oldest one owed
    task match_pixel(logic [OUT_TDATA_BITS-1:0] td, logic tl, logic tu);
      pixel_t want;
      seen++;
      if (pending.size() == 0) begin
        report($sformatf("pixel %0d arrived with none pending", seen));
        return;
      end
      want = pending.pop_front();
      compare("pix_row", 16'(td[11:0]), 16'(want.row));
      compare("pix_col", 16'(td[21:12]), 16'(want.col));
      compare("red", 16'(td[29:22]), 16'(want.red));
      compare("green", 16'(td[37:30]), 16'(want.green));
      compare("blue", 16'(td[45:38]), 16'(want.blue));
      compare("alpha", 16'(td[53:46]), 16'(want.alpha));
      compare("last_of_run", 16'(tl), 16'(want.last));
      compare("image_done", 16'(tu), 16'(want.done));
    endtask
  endclass

  logic                      clk           = 1'b0;
  logic                      rst           = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;   // [7:0] data_byte
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  // [11:0] pix_row, [21:12] pix_col, [29:22] red, [37:30] green,
  // [45:38] blue, [53:46] alpha, [55:54] zero
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic                      m_axis_tlast;         // last_of_run
  logic                      m_axis_tuser;         // image_done
  logic                      cfg_we        = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_index     = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data      = '0;

  pixel_tracker trk;
  gap_e         gap_mode  = GAP_NONE;
  int           hold_left = 0;
  int           cycles    = 0;

  pcx_rle_planar_to_rgba_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit sender_waits();
    int roll;
    roll = $urandom_range(0, 99);
    return (gap_mode == GAP_SEND && roll < 80) || (gap_mode == GAP_BOTH && roll < 10);
  endfunction

  function automatic bit receiver_waits();
    int roll;
    roll = $urandom_range(0, 99);
    return (gap_mode == GAP_RECV && roll < 80) || (gap_mode == GAP_BOTH && roll < 10);
  endfunction

  // Pixel side: check accepted pixels, then pick the next ready level
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        trk.match_pixel(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !receiver_waits();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One byte request; valid stays high afterwards so back-to-back requests need no gap
  task automatic push_byte(input logic [BYTE_BITS-1:0] b);
    while (sender_waits()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    trk.take_byte(b);
  endtask

  // Drop valid, wait for every owed pixel, then let any pixel-less run finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (trk.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    trk.set_reg(idx, val);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Runs of 63 until the current scanline closes, so the width can change safely
  task automatic finish_line();
    while (trk.fill != 0) begin
      push_byte(8'hFF);
      push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Mix of literals and marker/value pairs; zero counts now and then
  task automatic send_random(input int n);
    int sent;
    int cnt;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 35) begin
        cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 63);
        push_byte({RUN_MARK, RUN_BITS'(cnt)});
        push_byte(8'($urandom_range(0, 255)));
        sent += 2;
      end else begin
        push_byte(8'($urandom_range(0, 191)));
        sent++;
      end
    end
  endtask

  initial begin
    logic [BYTE_BITS-1:0] opening [14];
    int                   w;
    trk = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Width 4, height above the limit (clamped)
    write_reg(REG_IMAGE_WIDTH, 13'd4);
    write_reg(REG_IMAGE_HEIGHT, 13'h1fff);
    // zero-count run; red and green planes of zeros; black pixel; top literal;
    // run values with both top bits set; then a run of 63 overrunning the next line
    opening = '{8'hC0, 8'h55, 8'hC4, 8'h00, 8'hC4, 8'h00, 8'h00, 8'hBF,
                8'hC1, 8'hFF, 8'hC1, 8'hC0, 8'hFF, 8'h7F};
    foreach (opening[i]) push_byte(opening[i]);

    // Width lowered below the bytes already placed in the line
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'd2);
    push_byte(8'h11);
    push_byte(8'h22);
    push_byte(8'h33);
    push_byte(8'h44);
    push_byte(8'h55);
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'd1);
    push_byte(8'h66);

    // Random phases, each with its own width, height and idling
    for (int ph = 0; ph < 8; ph++) begin
      finish_line();
      settle();
      gap_mode = gap_e'(ph % 4);
      case (ph)
        0: w = 1;
        1: w = 0;
        3: w = $urandom_range(0, 1) ? DEF_MAX_WIDTH : 2047;
        default: w = $urandom_range(2, 12);
      endcase
      write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(w));
      write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'($urandom_range(trk.scan + 300, DEF_MAX_HEIGHT)));
      // long receiver hold while bytes keep coming
      if (ph == 4) hold_left <= HOLD_CYCLES;
      send_random((ph == 3) ? 10 : (ph == 4) ? 28 : 8);
    end

    // End of image, reached one of two ways
    finish_line();
    settle();
    gap_mode = GAP_BOTH;
    if ($urandom_range(0, 1)) begin
      write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(trk.scan + 1));
      while (!trk.finished) begin
        push_byte(8'hFF);
        push_byte(8'($urandom_range(0, 255)));
      end
    end else begin
      write_reg(REG_IMAGE_HEIGHT, '0);
    end
    // bytes after the image are ignored
    repeat (6) push_byte(8'($urandom_range(0, 255)));
    settle();

    if (trk.mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- pcx_rle_planar_to_rgba_top.f -----
sv/pcxrp_pkg.sv
sv/pcxrp_ram.sv
sv/pcxrp_cfg.sv
sv/pcxrp_pos.sv
sv/pcx_rle_planar_to_rgba_top.sv
tb/sv/tb.sv
